>>> rtl/tqd_pkg.sv
// Shared types and constants of the task queue with delay timers.
`timescale 1ns / 1ps
package tqd_pkg;

  localparam int unsigned QueueDepthDef = 8;
  localparam int unsigned TimerSlotsDef = 8;
  localparam int unsigned IdW           = 8;
  localparam int unsigned DelayW        = 16;
  localparam int unsigned QCountW       = 4;
  localparam int unsigned QCountMax     = 15;

  typedef enum logic [1:0] {
    CMD_ADD_TASK    = 2'd0,
    CMD_ADD_DELAYED = 2'd1,
    CMD_TAKE_NEXT   = 2'd2,
    CMD_TICK        = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [IdW-1:0]    task_id;
    logic [DelayW-1:0] delay_ticks;
    logic              update_existing;
  } cmd_t;

  typedef struct packed {
    logic [IdW-1:0]     next_task;
    logic               dropped;
    logic [QCountW-1:0] queue_count;
  } res_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

  typedef struct packed {
    logic wr_task;
    logic wr_cnt;
    logic set_valid;
    logic clr_valid;
  } slot_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP,
    ST_MATCH_RD,
    ST_MATCH_CMP,
    ST_FREE,
    ST_TICK_RD,
    ST_TICK_PROC,
    ST_DONE
  } state_e;

endpackage

>>> rtl/tqd_cmd_if.sv
// Command channel carrying one scheduler command per item.
`timescale 1ns / 1ps
interface tqd_cmd_if;
  logic          valid;
  logic          ready;
  tqd_pkg::cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/tqd_res_if.sv
// Result channel carrying one scheduler result per item.
`timescale 1ns / 1ps
interface tqd_res_if;
  logic          valid;
  logic          ready;
  tqd_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/tqd_alu.sv
// Shared 16-bit unit: decrement, equality compare and zero test.
`timescale 1ns / 1ps
module tqd_alu (
  input  logic [tqd_pkg::DelayW-1:0] a_i,
  input  logic [tqd_pkg::DelayW-1:0] b_i,
  output logic [tqd_pkg::DelayW-1:0] dec_o,
  output logic                       eq_o,
  output logic                       zero_o
);

  assign dec_o  = a_i - tqd_pkg::DelayW'(1);
  assign eq_o   = (a_i == b_i);
  assign zero_o = (a_i == '0);

endmodule

>>> rtl/tqd_fifo.sv
// Ready queue: circular buffer in a memory with head, tail and fill count.
`timescale 1ns / 1ps
module tqd_fifo #(
  parameter int unsigned QueueDepth = tqd_pkg::QueueDepthDef,
  localparam int unsigned PtrW = $clog2(QueueDepth),
  localparam int unsigned CntW = $clog2(QueueDepth + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tqd_pkg::fifo_ctl_t      ctl_i,
  input  logic [tqd_pkg::IdW-1:0] push_id_i,
  output logic [tqd_pkg::IdW-1:0] rd_data_o,
  output logic [CntW-1:0]         count_o,
  output logic                    full_o,
  output logic                    empty_o
);

  logic [tqd_pkg::IdW-1:0] mem [QueueDepth];
  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic [tqd_pkg::IdW-1:0] rd_q;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (ctl_i.push) begin
      tail_d  = wrap_inc(tail_q);
      count_d = count_q + CntW'(1);
    end else if (ctl_i.pop) begin
      head_d  = wrap_inc(head_q);
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem[tail_q] <= push_id_i;
    end
    rd_q <= mem[head_q];
  end

  assign rd_data_o = rd_q;
  assign count_o   = count_q;
  assign full_o    = (count_q == CntW'(QueueDepth));
  assign empty_o   = (count_q == '0);

endmodule

>>> rtl/tqd_slots.sv
// Timer slot table: task and countdown memories with an occupied bit per slot.
`timescale 1ns / 1ps
module tqd_slots #(
  parameter int unsigned TimerSlots = tqd_pkg::TimerSlotsDef,
  localparam int unsigned SlotW = (TimerSlots > 1) ? $clog2(TimerSlots) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [SlotW-1:0]           idx_i,
  input  tqd_pkg::slot_ctl_t         ctl_i,
  input  logic [tqd_pkg::IdW-1:0]    wr_task_i,
  input  logic [tqd_pkg::DelayW-1:0] wr_cnt_i,
  output logic [tqd_pkg::IdW-1:0]    rd_task_o,
  output logic [tqd_pkg::DelayW-1:0] rd_cnt_o,
  output logic                       rd_valid_o
);

  logic [tqd_pkg::IdW-1:0]    task_mem [TimerSlots];
  logic [tqd_pkg::DelayW-1:0] cnt_mem  [TimerSlots];
  logic [TimerSlots-1:0]      valid_q, valid_d;
  logic [tqd_pkg::IdW-1:0]    rd_task_q;
  logic [tqd_pkg::DelayW-1:0] rd_cnt_q;

  always_comb begin
    valid_d = valid_q;
    if (ctl_i.set_valid) begin
      valid_d[idx_i] = 1'b1;
    end else if (ctl_i.clr_valid) begin
      valid_d[idx_i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_task) begin
      task_mem[idx_i] <= wr_task_i;
    end
    if (ctl_i.wr_cnt) begin
      cnt_mem[idx_i] <= wr_cnt_i;
    end
    rd_task_q <= task_mem[idx_i];
    rd_cnt_q  <= cnt_mem[idx_i];
  end

  assign rd_task_o  = rd_task_q;
  assign rd_cnt_o   = rd_cnt_q;
  assign rd_valid_o = valid_q[idx_i];

endmodule

>>> rtl/task_queue_with_delay_timers.sv
// Task queue with delay timers: sequencer around a shared decrement/compare unit.
// Take next task pops the queue head unless the queue is empty.
// A tick reads each slot, then updates it, in turn.
// Add delayed task with a nonzero delay works through the slot scans.
// A new command is taken only when idle; an untaken result stalls the next in its done state.
// Reset is asynchronous and active low; queue and slots come up empty at once.
`timescale 1ns / 1ps
module task_queue_with_delay_timers #(
  parameter int unsigned QUEUE_DEPTH = tqd_pkg::QueueDepthDef,
  parameter int unsigned TIMER_SLOTS = tqd_pkg::TimerSlotsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  tqd_cmd_if.sink  cmd_i,
  tqd_res_if.source res_o
);

  localparam int unsigned SlotW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int unsigned CntW  = $clog2(QUEUE_DEPTH + 1);

  tqd_pkg::state_e state_q, state_d;
  tqd_pkg::cmd_t   cmd_q, cmd_d;
  logic [SlotW-1:0]            idx_q, idx_d;
  logic [tqd_pkg::DelayW-1:0]  cd_q, cd_d;
  logic [tqd_pkg::IdW-1:0]     next_q, next_d;
  logic                        drop_q, drop_d;
  tqd_pkg::res_t               res_q, res_d;
  logic                        out_valid_q, out_valid_d;
  logic                        res_load;

  tqd_pkg::fifo_ctl_t          fifo_ctl;
  logic [tqd_pkg::IdW-1:0]     push_id;
  logic [tqd_pkg::IdW-1:0]     fifo_rd;
  logic [CntW-1:0]             fifo_cnt;
  logic                        fifo_full, fifo_empty;

  tqd_pkg::slot_ctl_t          slot_ctl;
  logic [tqd_pkg::IdW-1:0]     slot_task;
  logic [tqd_pkg::DelayW-1:0]  slot_cnt, slot_wr_cnt;
  logic                        slot_valid;

  logic [tqd_pkg::DelayW-1:0]  alu_a, alu_b, alu_dec;
  logic                        alu_eq, alu_zero;
  logic                        idx_last;

  tqd_fifo #(.QueueDepth(QUEUE_DEPTH)) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (fifo_ctl),
    .push_id_i (push_id),
    .rd_data_o (fifo_rd),
    .count_o   (fifo_cnt),
    .full_o    (fifo_full),
    .empty_o   (fifo_empty)
  );

  tqd_slots #(.TimerSlots(TIMER_SLOTS)) u_slots (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .idx_i      (idx_q),
    .ctl_i      (slot_ctl),
    .wr_task_i  (cmd_q.task_id),
    .wr_cnt_i   (slot_wr_cnt),
    .rd_task_o  (slot_task),
    .rd_cnt_o   (slot_cnt),
    .rd_valid_o (slot_valid)
  );

  tqd_alu u_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .dec_o  (alu_dec),
    .eq_o   (alu_eq),
    .zero_o (alu_zero)
  );

  assign idx_last = (idx_q == SlotW'(TIMER_SLOTS - 1));

  // The shared unit sees the delay, an id pair or a countdown, by state.
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (state_q)
      tqd_pkg::ST_EXEC: begin
        alu_a = cmd_q.delay_ticks;
      end
      tqd_pkg::ST_MATCH_CMP: begin
        alu_a = tqd_pkg::DelayW'(slot_task);
        alu_b = tqd_pkg::DelayW'(cmd_q.task_id);
      end
      tqd_pkg::ST_TICK_PROC: begin
        alu_a = slot_cnt;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    cd_d        = cd_q;
    next_d      = next_q;
    drop_d      = drop_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    res_load    = 1'b0;
    fifo_ctl    = '0;
    push_id     = cmd_q.task_id;
    slot_ctl    = '0;
    slot_wr_cnt = cd_q;
    cmd_i.ready = (state_q == tqd_pkg::ST_IDLE);

    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      tqd_pkg::ST_IDLE: begin
        if (cmd_i.valid) begin
          cmd_d   = cmd_i.data;
          next_d  = '0;
          drop_d  = 1'b0;
          idx_d   = '0;
          state_d = tqd_pkg::ST_EXEC;
        end
      end
      tqd_pkg::ST_EXEC: begin
        state_d = tqd_pkg::ST_DONE;
        case (cmd_q.cmd)
          tqd_pkg::CMD_ADD_TASK, tqd_pkg::CMD_ADD_DELAYED: begin
            if (cmd_q.task_id != '0) begin
              if (cmd_q.cmd == tqd_pkg::CMD_ADD_TASK || alu_zero) begin
                if (fifo_full) begin
                  drop_d = 1'b1;
                end else begin
                  fifo_ctl.push = 1'b1;
                end
              end else begin
                cd_d    = alu_dec;
                state_d = cmd_q.update_existing ? tqd_pkg::ST_MATCH_RD
                                                : tqd_pkg::ST_FREE;
              end
            end
          end
          tqd_pkg::CMD_TAKE_NEXT: begin
            if (!fifo_empty) begin
              state_d = tqd_pkg::ST_POP;
            end
          end
          tqd_pkg::CMD_TICK: begin
            state_d = tqd_pkg::ST_TICK_RD;
          end
          default: begin
            state_d = tqd_pkg::ST_DONE;
          end
        endcase
      end
      tqd_pkg::ST_POP: begin
        next_d       = fifo_rd;
        fifo_ctl.pop = 1'b1;
        state_d      = tqd_pkg::ST_DONE;
      end
      tqd_pkg::ST_MATCH_RD: begin
        state_d = tqd_pkg::ST_MATCH_CMP;
      end
      tqd_pkg::ST_MATCH_CMP: begin
        if (slot_valid && alu_eq) begin
          slot_ctl.wr_cnt = 1'b1;
          state_d         = tqd_pkg::ST_DONE;
        end else if (idx_last) begin
          idx_d   = '0;
          state_d = tqd_pkg::ST_FREE;
        end else begin
          idx_d   = idx_q + SlotW'(1);
          state_d = tqd_pkg::ST_MATCH_RD;
        end
      end
      tqd_pkg::ST_FREE: begin
        if (!slot_valid) begin
          slot_ctl.wr_task   = 1'b1;
          slot_ctl.wr_cnt    = 1'b1;
          slot_ctl.set_valid = 1'b1;
          state_d            = tqd_pkg::ST_DONE;
        end else if (idx_last) begin
          drop_d  = 1'b1;
          state_d = tqd_pkg::ST_DONE;
        end else begin
          idx_d = idx_q + SlotW'(1);
        end
      end
      tqd_pkg::ST_TICK_RD: begin
        state_d = tqd_pkg::ST_TICK_PROC;
      end
      tqd_pkg::ST_TICK_PROC: begin
        if (slot_valid) begin
          if (alu_zero) begin
            // Expired: the slot frees even when the queue has no room.
            slot_ctl.clr_valid = 1'b1;
            push_id            = slot_task;
            if (fifo_full) begin
              drop_d = 1'b1;
            end else begin
              fifo_ctl.push = 1'b1;
            end
          end else begin
            slot_wr_cnt     = alu_dec;
            slot_ctl.wr_cnt = 1'b1;
          end
        end
        if (idx_last) begin
          state_d = tqd_pkg::ST_DONE;
        end else begin
          idx_d   = idx_q + SlotW'(1);
          state_d = tqd_pkg::ST_TICK_RD;
        end
      end
      tqd_pkg::ST_DONE: begin
        if (!out_valid_q || res_o.ready) begin
          res_load          = 1'b1;
          res_d.next_task   = next_q;
          res_d.dropped     = drop_q;
          res_d.queue_count = (32'(fifo_cnt) > 32'(tqd_pkg::QCountMax))
                              ? tqd_pkg::QCountW'(tqd_pkg::QCountMax)
                              : tqd_pkg::QCountW'(fifo_cnt);
          out_valid_d       = 1'b1;
          state_d           = tqd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tqd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tqd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    cd_q   <= cd_d;
    next_q <= next_d;
    drop_q <= drop_d;
    res_q  <= res_d;
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = res_q;

`ifndef SYNTHESIS
  // An accepted item always leaves the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready) |=> (state_q != tqd_pkg::ST_IDLE))
    else $error("block idle right after accepting an item");

  // The result register never overwrites a result that was not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!out_valid_q || res_o.ready))
    else $error("result overwritten before it was taken");

  // The queue fill rises by at most one per cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_cnt > $past(fifo_cnt)) |-> (fifo_cnt == $past(fifo_cnt) + CntW'(1)))
    else $error("queue fill jumped by more than one");

  // A popped task never comes with a drop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> !(res_o.data.dropped && (res_o.data.next_task != '0)))
    else $error("result reports both a popped task and a drop");

  // The queue never holds more entries than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_ctl.push |-> !fifo_full)
    else $error("push into a full queue");
`endif

endmodule
